>>> hdl/pfn_pkg.sv
// shared types, constants and command/status bundles of the polygon face normal block
package pfn_pkg;

	localparam int MAX_VERTS = 64;
	localparam int CNT_W     = $clog2(MAX_VERTS + 2);
	localparam int CRD_W     = 16;
	localparam int DIFF_W    = CRD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CORN_W    = PROD_W + 1;
	localparam int SUM_W     = 40;
	localparam int MAG_W     = 30;
	localparam int SQ_W      = 63;
	localparam int ROOT_W    = 32;
	localparam int QUO_W     = 15;
	localparam int NUM_W     = MAG_W + QUO_W + 1;
	localparam int OUT_W     = 16;
	localparam int SQRT_STEPS = SQ_W / 2 + 1;
	localparam int STEP_W    = $clog2(SQRT_STEPS);

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
	} vtx_t;

	typedef enum logic [1:0] {
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	typedef enum logic [1:0] {
		CN_STREAM,
		CN_WRAP0,
		CN_WRAP1
	} corner_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MULX,
		ST_MULY,
		ST_MULZ,
		ST_ACCZ,
		ST_SHIFT,
		ST_FINAL,
		ST_CHECK,
		ST_SCALE,
		ST_SQ,
		ST_RINIT,
		ST_SQRT,
		ST_DLOAD,
		ST_DSTEP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic    load_vtx;
		logic    wr_f0;
		logic    wr_f1;
		corner_t corner;
		logic    diff_en;
		logic    mul_en;
		comp_t   mul_sel;
		logic    acc_en;
		comp_t   acc_sel;
		logic    shift_recent;
		logic    clear_face;
		logic    mag_load;
		logic    scale_shift;
		logic    sq_en;
		comp_t   sq_sel;
		logic    sqrt_init;
		logic    sqrt_step;
		logic    div_load;
		logic    div_step;
		logic    div_last;
		comp_t   div_sel;
		logic    out_load;
		logic    degen;
	} pfn_cmd_t;

	typedef struct packed {
		logic zero_sum;
		logic big;
	} pfn_stat_t;

endpackage

>>> hdl/polygon_face_normal_core.sv
// top level of the polygon face normal block: sequencer plus datapath
//
// vertex channel: in_valid / in_stall carry vx, vy, vz and last_vertex; a transfer
// happens on a rising edge with in_valid high and in_stall low. vertices of a face
// come in order, last_vertex marks the final one.
// result channel: out_valid / out_stall carry norm_x, norm_y, norm_z (signed Q1.14)
// and degenerate; one result per face, a transfer on out_valid high, out_stall low.
// a vertex that closes a corner runs transfer, difference, three multiply/accumulate
// steps, accumulate and shift; the first two vertices of a face run only transfer and
// shift. the cost is set by the shared pair of 17x17 multipliers, one cross
// product component per cycle.
// after the final vertex, a face of more than three vertices runs two wrap-around corners;
// then magnitude scaling, three squares, a 32-step square root and three divides lead
// to out_valid. a face of under three vertices or with a zero sum goes to a degenerate result.
// the result sits in an output register; the next face's vertices are taken while
// it waits. a new result waits in the last step until the old one is taken.
// reset clears the sums, the vertex count, the state and out_valid; no clearing pass.
module polygon_face_normal_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [pfn_pkg::CRD_W-1:0] vx,
	input  logic signed [pfn_pkg::CRD_W-1:0] vy,
	input  logic signed [pfn_pkg::CRD_W-1:0] vz,
	input  logic                             last_vertex,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [pfn_pkg::OUT_W-1:0] norm_x,
	output logic signed [pfn_pkg::OUT_W-1:0] norm_y,
	output logic signed [pfn_pkg::OUT_W-1:0] norm_z,
	output logic                             degenerate
);
	import pfn_pkg::*;

	// command and status bundles between sequencer and datapath
	pfn_cmd_t  cmd;
	pfn_stat_t stat;

	// sequencer: vertex count, face flags, iteration counters, output valid
	pfn_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_vertex (last_vertex),
		.out_stall   (out_stall),
		.stat        (stat),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	// datapath: vertex store, cross product sums, root and divide, result register
	pfn_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.vx         (vx),
		.vy         (vy),
		.vz         (vz),
		.stat       (stat),
		.norm_x     (norm_x),
		.norm_y     (norm_y),
		.norm_z     (norm_z),
		.degenerate (degenerate)
	);

endmodule

>>> hdl/pfn_ctrl.sv
// sequencer of the polygon face normal block: vertex flow, corners, normalize, result
module pfn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_vertex,
	input  logic               out_stall,
	input  pfn_pkg::pfn_stat_t stat,
	output logic               in_stall,
	output logic               out_valid,
	output pfn_pkg::pfn_cmd_t  cmd
);
	import pfn_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             last_q;
	corner_t          corner_q;
	logic [STEP_W-1:0] cnt_q;
	logic [1:0]       idx_q;
	logic             degen_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;
	logic             cnt_end_div;

	assign accept      = in_valid && (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || !out_stall;
	assign cnt_end_div = (cnt_q == STEP_W'(QUO_W - 1));
	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q < CNT_W'(MAX_VERTS))
						state_d = (count_q >= CNT_W'(2)) ? ST_DIFF : ST_SHIFT;
					else
						state_d = last_vertex ? ST_FINAL : ST_IDLE;
				end
			end
			ST_DIFF:  state_d = ST_MULX;
			ST_MULX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_MULZ;
			ST_MULZ:  state_d = ST_ACCZ;
			ST_ACCZ: begin
				case (corner_q)
					CN_STREAM: state_d = ST_SHIFT;
					CN_WRAP0:  state_d = ST_DIFF;
					CN_WRAP1:  state_d = ST_CHECK;
					default:   state_d = ST_SHIFT;
				endcase
			end
			ST_SHIFT: state_d = last_q ? ST_FINAL : ST_IDLE;
			ST_FINAL: begin
				if (count_q < CNT_W'(3) || count_q > CNT_W'(MAX_VERTS))
					state_d = ST_OUT;
				else if (count_q > CNT_W'(3))
					state_d = ST_DIFF;
				else
					state_d = ST_CHECK;
			end
			ST_CHECK: state_d = stat.zero_sum ? ST_OUT : ST_SCALE;
			ST_SCALE: state_d = stat.big ? ST_SCALE : ST_SQ;
			ST_SQ:    state_d = (idx_q == 2'(COMP_Z)) ? ST_RINIT : ST_SQ;
			ST_RINIT: state_d = ST_SQRT;
			ST_SQRT:  state_d = (cnt_q == STEP_W'(SQRT_STEPS - 1)) ? ST_DLOAD : ST_SQRT;
			ST_DLOAD: state_d = ST_DSTEP;
			ST_DSTEP: begin
				if (cnt_end_div)
					state_d = (idx_q == 2'(COMP_Z)) ? ST_OUT : ST_DLOAD;
			end
			ST_OUT:   state_d = out_free ? ST_IDLE : ST_OUT;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.corner   = corner_q;
		cmd.sq_sel   = comp_t'(idx_q);
		cmd.div_sel  = comp_t'(idx_q);
		cmd.degen    = degen_q;
		cmd.load_vtx = accept;
		cmd.wr_f0    = accept && (count_q == CNT_W'(0));
		cmd.wr_f1    = accept && (count_q == CNT_W'(1));
		case (state_q)
			ST_DIFF: cmd.diff_en = 1'b1;
			ST_MULX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = COMP_X;
			end
			ST_MULY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = COMP_Y;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = COMP_X;
			end
			ST_MULZ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = COMP_Z;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = COMP_Y;
			end
			ST_ACCZ: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = COMP_Z;
			end
			ST_SHIFT: cmd.shift_recent = 1'b1;
			ST_CHECK: cmd.mag_load = !stat.zero_sum;
			ST_SCALE: cmd.scale_shift = stat.big;
			ST_SQ:    cmd.sq_en = 1'b1;
			ST_RINIT: cmd.sqrt_init = 1'b1;
			ST_SQRT:  cmd.sqrt_step = 1'b1;
			ST_DLOAD: cmd.div_load = 1'b1;
			ST_DSTEP: begin
				cmd.div_step = 1'b1;
				cmd.div_last = cnt_end_div;
			end
			ST_OUT: begin
				cmd.out_load   = out_free;
				cmd.clear_face = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			last_q      <= 1'b0;
			corner_q    <= CN_STREAM;
			cnt_q       <= '0;
			idx_q       <= '0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				last_q   <= last_vertex;
				corner_q <= CN_STREAM;
				if (count_q <= CNT_W'(MAX_VERTS))
					count_q <= count_q + CNT_W'(1);
			end

			if (state_q == ST_FINAL) begin
				corner_q <= CN_WRAP0;
				degen_q  <= (count_q < CNT_W'(3)) || (count_q > CNT_W'(MAX_VERTS));
			end
			if (state_q == ST_ACCZ && corner_q == CN_WRAP0)
				corner_q <= CN_WRAP1;
			if (state_q == ST_CHECK && stat.zero_sum)
				degen_q <= 1'b1;

			// iteration counter for the root and the quotient
			if (state_q == ST_SQRT || state_q == ST_DSTEP)
				cnt_q <= (state_q == ST_DSTEP && cnt_end_div) ? '0 : cnt_q + STEP_W'(1);
			else
				cnt_q <= '0;

			// component index
			case (state_q)
				ST_SCALE: idx_q <= '0;
				ST_SQ:    idx_q <= (idx_q == 2'(COMP_Z)) ? '0 : idx_q + 2'd1;
				ST_SQRT:  idx_q <= '0;
				ST_DSTEP: if (cnt_end_div) idx_q <= idx_q + 2'd1;
				default: ;
			endcase

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/pfn_dp.sv
// datapath of the polygon face normal block: vertex store, cross products, sums, root, divide
module pfn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfn_pkg::pfn_cmd_t            cmd,
	input  logic signed [pfn_pkg::CRD_W-1:0] vx,
	input  logic signed [pfn_pkg::CRD_W-1:0] vy,
	input  logic signed [pfn_pkg::CRD_W-1:0] vz,
	output pfn_pkg::pfn_stat_t           stat,
	output logic signed [pfn_pkg::OUT_W-1:0] norm_x,
	output logic signed [pfn_pkg::OUT_W-1:0] norm_y,
	output logic signed [pfn_pkg::OUT_W-1:0] norm_z,
	output logic                         degenerate
);
	import pfn_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	vtx_t v_q, f0_q, f1_q, r0_q, r1_q;
	vtx_t p, c, n;

	logic signed [DIFF_W-1:0] dpx_q, dpy_q, dpz_q, dnx_q, dny_q, dnz_q;
	logic signed [DIFF_W-1:0] ma, mb, mc, md;
	logic signed [PROD_W-1:0] pa_q, pb_q;
	logic signed [CORN_W-1:0] corner;
	logic signed [SUM_W-1:0]  sum_x_q, sum_y_q, sum_z_q, sum_cur, sum_new;
	logic signed [SUM_W:0]    sum_wide;

	logic [SUM_W-1:0]  a_x_q, a_y_q, a_z_q, a_sq, a_dv;
	logic [2*MAG_W-1:0] sq_prod;
	logic [SQ_W-1:0]   q_q;
	logic [SQ_W-1:0]   sv_q, sres_q, sbit_q, s_try;
	logic [NUM_W-1:0]  num_q, dsh_q;
	logic [QUO_W-1:0]  quo_q, res_x_q, res_y_q, res_z_q;
	logic              q_bit;

	logic signed [OUT_W-1:0] nx_q, ny_q, nz_q;
	logic                    degen_q;

	function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] s);
		mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
	endfunction

	function automatic logic signed [OUT_W-1:0] signed_out(input logic [QUO_W-1:0] o,
			input logic signed [SUM_W-1:0] s);
		logic signed [OUT_W-1:0] w;
		w = OUT_W'({1'b0, o});
		signed_out = (s > 0) ? -w : w;
	endfunction

	// corner operands
	always_comb begin
		case (cmd.corner)
			CN_STREAM: begin p = r0_q; c = r1_q; n = v_q;  end
			CN_WRAP0:  begin p = r0_q; c = r1_q; n = f0_q; end
			CN_WRAP1:  begin p = r1_q; c = f0_q; n = f1_q; end
			default:   begin p = r0_q; c = r1_q; n = v_q;  end
		endcase
	end

	// multiplier operands per cross product component
	always_comb begin
		case (cmd.mul_sel)
			COMP_X:  begin ma = dpy_q; mb = dnz_q; mc = dpz_q; md = dny_q; end
			COMP_Y:  begin ma = dpz_q; mb = dnx_q; mc = dpx_q; md = dnz_q; end
			COMP_Z:  begin ma = dpx_q; mb = dny_q; mc = dpy_q; md = dnx_q; end
			default: begin ma = dpy_q; mb = dnz_q; mc = dpz_q; md = dny_q; end
		endcase
	end

	assign corner = CORN_W'(pa_q) - CORN_W'(pb_q);

	always_comb begin
		case (cmd.acc_sel)
			COMP_X:  sum_cur = sum_x_q;
			COMP_Y:  sum_cur = sum_y_q;
			COMP_Z:  sum_cur = sum_z_q;
			default: sum_cur = sum_x_q;
		endcase
		sum_wide = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(corner);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_new = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		else
			sum_new = sum_wide[SUM_W-1:0];
	end

	always_comb begin
		case (cmd.sq_sel)
			COMP_X:  a_sq = a_x_q;
			COMP_Y:  a_sq = a_y_q;
			COMP_Z:  a_sq = a_z_q;
			default: a_sq = a_x_q;
		endcase
		case (cmd.div_sel)
			COMP_X:  a_dv = a_x_q;
			COMP_Y:  a_dv = a_y_q;
			COMP_Z:  a_dv = a_z_q;
			default: a_dv = a_x_q;
		endcase
	end

	// full-width square of a scaled magnitude
	assign sq_prod = (2*MAG_W)'(a_sq[MAG_W-1:0]) * (2*MAG_W)'(a_sq[MAG_W-1:0]);

	assign s_try = sres_q + sbit_q;
	assign q_bit = (num_q >= dsh_q);

	assign stat.zero_sum = (sum_x_q == '0) && (sum_y_q == '0) && (sum_z_q == '0);
	assign stat.big      = (|a_x_q[SUM_W-1:MAG_W]) || (|a_y_q[SUM_W-1:MAG_W])
	                    || (|a_z_q[SUM_W-1:MAG_W]);

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (cmd.clear_face) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (cmd.acc_en) begin
			case (cmd.acc_sel)
				COMP_X:  sum_x_q <= sum_new;
				COMP_Y:  sum_y_q <= sum_new;
				COMP_Z:  sum_z_q <= sum_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vtx) begin
			v_q <= '{x: vx, y: vy, z: vz};
			if (cmd.wr_f0) f0_q <= '{x: vx, y: vy, z: vz};
			if (cmd.wr_f1) f1_q <= '{x: vx, y: vy, z: vz};
		end
		if (cmd.shift_recent) begin
			r0_q <= r1_q;
			r1_q <= v_q;
		end
		if (cmd.diff_en) begin
			dpx_q <= DIFF_W'($signed(p.x)) - DIFF_W'($signed(c.x));
			dpy_q <= DIFF_W'($signed(p.y)) - DIFF_W'($signed(c.y));
			dpz_q <= DIFF_W'($signed(p.z)) - DIFF_W'($signed(c.z));
			dnx_q <= DIFF_W'($signed(n.x)) - DIFF_W'($signed(c.x));
			dny_q <= DIFF_W'($signed(n.y)) - DIFF_W'($signed(c.y));
			dnz_q <= DIFF_W'($signed(n.z)) - DIFF_W'($signed(c.z));
		end
		if (cmd.mul_en) begin
			pa_q <= PROD_W'(ma) * PROD_W'(mb);
			pb_q <= PROD_W'(mc) * PROD_W'(md);
		end

		// magnitudes, scaled until all fit the squaring width
		if (cmd.mag_load) begin
			a_x_q <= mag(sum_x_q);
			a_y_q <= mag(sum_y_q);
			a_z_q <= mag(sum_z_q);
			q_q   <= '0;
		end else if (cmd.scale_shift) begin
			a_x_q <= a_x_q >> 1;
			a_y_q <= a_y_q >> 1;
			a_z_q <= a_z_q >> 1;
		end
		if (cmd.sq_en)
			q_q <= q_q + SQ_W'(sq_prod);

		// bit-pair integer square root
		if (cmd.sqrt_init) begin
			sv_q   <= q_q;
			sres_q <= '0;
			sbit_q <= SQ_W'(1) << (SQ_W - 1);
		end else if (cmd.sqrt_step) begin
			if (sv_q >= s_try) begin
				sv_q   <= sv_q - s_try;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end

		// restoring divide of (2a*2^14 + r) by 2r
		if (cmd.div_load) begin
			num_q <= NUM_W'({a_dv[MAG_W-1:0], {QUO_W{1'b0}}}) + NUM_W'(sres_q[ROOT_W-1:0]);
			dsh_q <= NUM_W'({sres_q[ROOT_W-1:0], 1'b0}) << (QUO_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (q_bit)
				num_q <= num_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], q_bit};
			if (cmd.div_last) begin
				case (cmd.div_sel)
					COMP_X:  res_x_q <= {quo_q[QUO_W-2:0], q_bit};
					COMP_Y:  res_y_q <= {quo_q[QUO_W-2:0], q_bit};
					COMP_Z:  res_z_q <= {quo_q[QUO_W-2:0], q_bit};
					default: ;
				endcase
			end
		end

		// result register, sign opposite to the sum
		if (cmd.out_load) begin
			degen_q <= cmd.degen;
			nx_q    <= cmd.degen ? '0 : signed_out(res_x_q, sum_x_q);
			ny_q    <= cmd.degen ? '0 : signed_out(res_y_q, sum_y_q);
			nz_q    <= cmd.degen ? '0 : signed_out(res_z_q, sum_z_q);
		end
	end

	assign norm_x     = nx_q;
	assign norm_y     = ny_q;
	assign norm_z     = nz_q;
	assign degenerate = degen_q;

endmodule
